@@ src/bdq_pkg.sv @@
// Shared codes for the bounded deque core: operation and status encodings.
// No dependencies.

package bdq_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

@@ src/bdq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/bounded_deque_with_match_count_core.sv @@
// Bounded double-ended queue of 32-bit words held in a ring RAM, with a match counter.
// Depends on bdq_pkg and bdq_ram.
//
// A request is taken when start is high and busy is low. Pushes, removals and
// unused op codes complete directly: the result strobe comes on the cycle
// after the request and busy stays low, so a new request can follow at once.
// A count request walks the stored entries through the RAM's single read
// port, one entry per cycle; busy is high and the result strobe arrives
// after one read per entry, the RAM's registered read and the result register
// (on an empty store it comes on the cycle after the request, as for a push).
// out_strobe is high for exactly one cycle per request and the receiver cannot
// hold it off, so the result must be captured then. A push into a full store
// answers status 1, a removal from an empty store answers status 2; neither
// changes the contents. No clearing pass is run after reset: only occupied
// slots are ever read.

module bounded_deque_with_match_count_core
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [OP_W-1:0]                   in_op,
  input  logic signed [WORD_W-1:0]          in_value,
  output logic                              out_strobe,
  output logic [STATUS_W-1:0]               out_status,
  output logic [$clog2(CAPACITY+1)-1:0]     out_match_count,
  output logic [$clog2(CAPACITY+1)-1:0]     out_occupancy
);

  localparam int unsigned IW = $clog2(CAPACITY);      // slot index width
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // count width

  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
  localparam logic [IW:0]   CAP_WIDE  = (IW + 1)'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  // Control state
  state_t             state_r, state_nxt;
  logic [IW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  // Scan bookkeeping
  logic [CW-1:0]      iss_r, iss_nxt;       // reads issued so far
  logic [IW-1:0]      rd_slot_r, rd_slot_nxt;
  logic               rd_pend_r, rd_pend_nxt; // RAM data valid this cycle
  logic [CW-1:0]      acc_r, acc_nxt;
  logic [WORD_W-1:0]  value_r, value_nxt;
  // Result register
  logic               out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [CW-1:0]      out_match_r, out_match_nxt;
  logic [CW-1:0]      out_occ_r, out_occ_nxt;

  // RAM port signals
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic               ram_re;
  logic [WORD_W-1:0]  ram_rdata;

  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic [IW-1:0]      front_dec;
  logic [IW-1:0]      front_inc;
  logic [IW-1:0]      rd_slot_inc;
  logic [IW:0]        back_sum;
  logic [IW-1:0]      back_slot;
  logic               hit;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (cnt_r == CAP_CNT);
  assign is_empty = (cnt_r == '0);

  // Ring arithmetic, wrapping at CAPACITY (need not be a power of two).
  assign front_dec   = (front_r == '0) ? LAST_SLOT : front_r - IW'(1);
  assign front_inc   = (front_r == LAST_SLOT) ? '0 : front_r + IW'(1);
  assign rd_slot_inc = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + IW'(1);
  // Slot just past the back entry; only used when not full, so cnt < CAPACITY.
  assign back_sum    = {1'b0, front_r} + {1'b0, cnt_r[IW-1:0]};
  assign back_slot   = (back_sum >= CAP_WIDE) ? IW'(back_sum - CAP_WIDE) : back_sum[IW-1:0];

  assign hit = rd_pend_r && (ram_rdata == value_r);

  // Pushes write the RAM on the accept edge itself.
  assign ram_we    = accept && (in_op inside {OP_PUSH_FRONT, OP_PUSH_BACK}) && !is_full;
  assign ram_waddr = (in_op == OP_PUSH_FRONT) ? front_dec : back_slot;
  // One read per cycle while entries remain to be fetched.
  assign ram_re    = (state_r == S_SCAN) && (iss_r != cnt_r);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    cnt_nxt        = cnt_r;
    iss_nxt        = iss_r;
    rd_slot_nxt    = rd_slot_r;
    rd_pend_nxt    = 1'b0;
    acc_nxt        = acc_r;
    value_nxt      = value_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_match_nxt  = out_match_r;
    out_occ_nxt    = out_occ_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_DONE;
          out_match_nxt  = '0;
          case (in_op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                front_nxt = front_dec;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                front_nxt = front_inc;
                cnt_nxt   = cnt_r - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            OP_COUNT: begin
              value_nxt = unsigned'(in_value);
              if (!is_empty) begin
                state_nxt   = S_SCAN;
                iss_nxt     = '0;
                rd_slot_nxt = front_r;
                acc_nxt     = '0;
              end
            end
            default: begin
              // unused codes: no change, plain done
            end
          endcase
          // Count on an empty store answers right away.
          out_strobe_nxt = !((in_op == OP_COUNT) && !is_empty);
          out_occ_nxt    = cnt_nxt;
        end
      end
      S_SCAN: begin
        if (ram_re) begin
          iss_nxt     = iss_r + CW'(1);
          rd_slot_nxt = rd_slot_inc;
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          acc_nxt = acc_r + CW'(hit);
        end
        // Last word back from the RAM: report.
        if (rd_pend_r && (iss_r == cnt_r)) begin
          state_nxt      = S_IDLE;
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_DONE;
          out_match_nxt  = acc_r + CW'(hit);
          out_occ_nxt    = cnt_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      cnt_r        <= '0;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      cnt_r        <= cnt_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    rd_slot_r    <= rd_slot_nxt;
    acc_r        <= acc_nxt;
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_match_r  <= out_match_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  bdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (unsigned'(in_value)),
    .re    (ram_re),
    .raddr (rd_slot_r),
    .rdata (ram_rdata)
  );

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_match_count = out_match_r;
  assign out_occupancy   = out_occ_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_occ_r <= CAP_CNT))
    else $error("occupancy above capacity");

  a_refused_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_status_r != ST_DONE)) |-> (out_match_r == '0))
    else $error("refused request reports matches");

  a_match_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_match_r <= out_occ_r))
    else $error("match count above occupancy");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("push did not grow occupancy");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !ram_we)
    else $error("store written during a count walk");
`endif

endmodule
